[hw/rtl/uwfc_pkg.sv]
// Package for the UTF-8 word frequency counter: payload types, action codes,
// sizes and the code point class function. No dependencies.
package uwfc_pkg;

  localparam int unsigned TableEntries    = 64;
  localparam int unsigned WordBufferBytes = 32;
  localparam int unsigned SlotW  = $clog2(TableEntries);
  localparam int unsigned UsedW  = $clog2(TableEntries + 1);
  localparam int unsigned PosW   = $clog2(WordBufferBytes);
  localparam int unsigned LenW   = $clog2(WordBufferBytes + 1);
  localparam int unsigned AddrW  = SlotW + PosW;

  typedef enum logic [1:0] {
    KindByte  = 2'd0,
    KindFlush = 2'd1,
    KindClear = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ActRaised   = 2'd0,
    ActAppended = 2'd1,
    ActReplaced = 2'd2,
    ActDropped  = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  slot_index;
    logic [31:0] slot_count;
    logic [4:0]  word_length;
  } out_word_t;

  // Class a code point as part of a word.
  function automatic logic is_word_cp(input logic [20:0] cp);
    logic r;
    r = 1'b1;
    if (cp < 21'h80) begin
      r = (cp >= 21'h61 && cp <= 21'h7A) || (cp >= 21'h41 && cp <= 21'h5A) ||
          (cp >= 21'h30 && cp <= 21'h39) || cp == 21'h5F || cp == 21'h2D;
    end else if (cp == 21'h00A0 || cp == 21'h1680 || cp == 21'h180E ||
                 (cp >= 21'h2000 && cp <= 21'h206F) ||
                 (cp >= 21'h2E00 && cp <= 21'h2E7F) ||
                 (cp >= 21'h3000 && cp <= 21'h303F) ||
                 (cp >= 21'hFE30 && cp <= 21'hFE4F)) begin
      r = 1'b0;
    end
    return r;
  endfunction

endpackage

[hw/rtl/utf8_word_frequency_counter.sv]
// Top level of the UTF-8 word frequency counter: decoder, word buffer and
// table walker over byte, length and count memories. Uses uwfc_pkg.
//
//  channel | ports                          | handshake
//  input   | start_i, busy_o, in_word_i     | taken when start_i && !busy_o
//  result  | res_valid_o, res_word_o        | one-cycle strobe, no backpressure
//
// The last byte of a code point that extends a word holds busy_o through
// StDecode, StRedo and StAppend; a lead byte through StDecode, a middle byte
// through StDecode and StRedo. A finished word walks the table: per used slot,
// StLenRd and StLenChk check length and first byte, then StByteChk compares
// one byte per cycle from the byte memory (one read port); a full table adds
// a count pass for replacement, StWrite writes len bytes, and a hit goes
// through StCntRd and StCntUpd. Reset clears the decoder, the buffer length
// and the fill count; the memories are not cleared. The receiver cannot stall.
module utf8_word_frequency_counter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  uwfc_pkg::in_word_t   in_word_i,
  output logic                 busy_o,
  output logic                 res_valid_o,
  output uwfc_pkg::out_word_t  res_word_o
);

  typedef enum logic [3:0] {
    StIdle, StDecode, StAppend, StFinish, StLenRd, StLenChk, StByteChk,
    StMinRd, StMinChk, StCntRd, StCntUpd, StWrite, StRedo
  } state_e;

  state_e state_q;
  logic [7:0] byte_q;
  logic [7:0] pend_q [3];
  logic [1:0] pcnt_q;
  logic [7:0] seq_q [4];
  logic [2:0] seqn_q;
  logic [7:0] wbuf_q [uwfc_pkg::WordBufferBytes];
  logic [uwfc_pkg::LenW-1:0] wlen_q;
  logic [uwfc_pkg::UsedW-1:0] used_q;
  logic [uwfc_pkg::UsedW-1:0] slot_q;
  logic [uwfc_pkg::PosW-1:0] pos_q;
  logic [2:0] apos_q;
  logic [uwfc_pkg::SlotW-1:0] weak_q;
  logic [31:0] wcnt_q;
  logic [uwfc_pkg::SlotW-1:0] tgt_q;
  logic [1:0] act_q;
  logic after_q;   // resume appending cp after finish
  logic redo_q;    // decode byte_q fresh after finish

  // Memories
  localparam int unsigned TableDepthB = uwfc_pkg::TableEntries * uwfc_pkg::WordBufferBytes;
  logic [7:0] bmem [TableDepthB];
  logic [uwfc_pkg::LenW-1:0] lmem [uwfc_pkg::TableEntries];
  logic [31:0] cmem [uwfc_pkg::TableEntries];
  logic [7:0] brd_q;
  logic [uwfc_pkg::LenW-1:0] lrd_q;
  logic [31:0] crd_q;
  logic [uwfc_pkg::AddrW-1:0] braddr, bwaddr;
  logic [uwfc_pkg::SlotW-1:0] lcaddr;
  logic bwe, lwe, cwe;
  logic [7:0] bwdata;
  logic [31:0] cwdata;

  assign busy_o = (state_q != StIdle);

  // Decode of the completed sequence
  logic [2:0] need;
  logic [20:0] cp;
  logic cpword;
  always_comb begin
    need = 3'd4;
    if (seq_q[0][7:5] == 3'b110) need = 3'd2;
    else if (seq_q[0][7:4] == 4'b1110) need = 3'd3;
    else if (seq_q[0][7] == 1'b0) need = 3'd1;
    unique case (need)
      3'd1: cp = {14'd0, seq_q[0][6:0]};
      3'd2: cp = {10'd0, seq_q[0][4:0], seq_q[1][5:0]};
      3'd3: cp = {5'd0, seq_q[0][3:0], seq_q[1][5:0], seq_q[2][5:0]};
      default: cp = {seq_q[0][2:0], seq_q[1][5:0], seq_q[2][5:0], seq_q[3][5:0]};
    endcase
    cpword = uwfc_pkg::is_word_cp(cp);
  end

  logic bslot_full;
  assign bslot_full = (used_q == uwfc_pkg::UsedW'(uwfc_pkg::TableEntries));

  // Memory port selection; the byte read runs one position ahead of the compare
  always_comb begin
    lcaddr = slot_q[uwfc_pkg::SlotW-1:0];
    if (state_q == StWrite || state_q == StCntUpd) lcaddr = tgt_q;
    braddr = {slot_q[uwfc_pkg::SlotW-1:0], pos_q};
    if (state_q == StLenRd) begin
      braddr = {slot_q[uwfc_pkg::SlotW-1:0], uwfc_pkg::PosW'(0)};
    end else if (state_q == StLenChk) begin
      braddr = {slot_q[uwfc_pkg::SlotW-1:0], uwfc_pkg::PosW'(1)};
    end else if (state_q == StByteChk) begin
      braddr = {slot_q[uwfc_pkg::SlotW-1:0], pos_q + uwfc_pkg::PosW'(1)};
    end
    bwaddr = {tgt_q, pos_q};
    bwdata = wbuf_q[pos_q];
    bwe = (state_q == StWrite);
    lwe = (state_q == StWrite) && (pos_q == '0);
    cwe = ((state_q == StWrite) && (pos_q == '0)) || (state_q == StCntUpd);
    cwdata = (state_q == StCntUpd) ? ((crd_q == 32'hFFFF_FFFF) ? crd_q : crd_q + 32'd1)
                                   : 32'd1;
  end

  always_ff @(posedge clk_i) begin
    if (bwe) bmem[bwaddr] <= bwdata;
    brd_q <= bmem[braddr];
  end
  always_ff @(posedge clk_i) begin
    if (lwe) lmem[lcaddr] <= wlen_q;
    lrd_q <= lmem[lcaddr];
  end
  always_ff @(posedge clk_i) begin
    if (cwe) cmem[lcaddr] <= cwdata;
    crd_q <= cmem[lcaddr];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pcnt_q <= '0;
      wlen_q <= '0;
      used_q <= '0;
      res_valid_o <= 1'b0;
      after_q <= 1'b0;
      redo_q <= 1'b0;
    end else begin
      // Strobe a result in the cycle after the states that finish a word
      res_valid_o <= (state_q == StCntUpd) ||
                     (state_q == StMinChk && wcnt_q > 32'd1) ||
                     (state_q == StWrite && uwfc_pkg::LenW'(pos_q) + 1'b1 == wlen_q);
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            byte_q <= in_word_i.text_byte;
            unique case (uwfc_pkg::kind_e'(in_word_i.kind))
              uwfc_pkg::KindByte:  state_q <= StDecode;
              uwfc_pkg::KindFlush: begin
                pcnt_q <= '0;
                after_q <= 1'b0;
                redo_q <= 1'b0;
                state_q <= StFinish;
              end
              uwfc_pkg::KindClear: used_q <= '0;
              default: ;
            endcase
          end
        end
        StDecode: begin
          after_q <= 1'b0;
          // broken sequence: separator, then decode byte afresh
          redo_q <= (pcnt_q != 2'd0) && (byte_q[7:6] != 2'b10);
          if (pcnt_q == 2'd0) begin
            if (!byte_q[7]) begin
              seq_q[0] <= byte_q;
              seqn_q <= 3'd1;
              state_q <= StRedo;
            end else if (byte_q[7:5] == 3'b110 || byte_q[7:4] == 4'b1110 ||
                         byte_q[7:3] == 5'b11110) begin
              pend_q[0] <= byte_q;
              pcnt_q <= 2'd1;
              state_q <= StIdle;
            end else begin
              state_q <= StFinish;
            end
          end else if (byte_q[7:6] != 2'b10) begin
            pcnt_q <= '0;
            state_q <= StFinish;
          end else begin
            for (int i = 0; i < 3; i++) begin
              seq_q[i] <= (2'(i) == pcnt_q) ? byte_q : pend_q[i];
            end
            if (pcnt_q == 2'd3) seq_q[3] <= byte_q;
            seqn_q <= {1'b0, pcnt_q} + 3'd1;
            state_q <= StRedo;
          end
        end
        StRedo: begin
          // seq_q holds seqn_q bytes
          if (seqn_q < need) begin
            pend_q[seqn_q[1:0] - 2'd1] <= seq_q[seqn_q[1:0] - 2'd1];
            pcnt_q <= seqn_q[1:0];
            state_q <= StIdle;
          end else begin
            pcnt_q <= '0;
            if (!cpword) begin
              state_q <= StFinish;
            end else if (uwfc_pkg::LenW'(wlen_q + uwfc_pkg::LenW'(need)) >=
                         uwfc_pkg::LenW'(uwfc_pkg::WordBufferBytes)) begin
              after_q <= 1'b1;
              state_q <= StFinish;
            end else begin
              apos_q <= '0;
              state_q <= StAppend;
            end
          end
        end
        StAppend: begin
          if (apos_q == need) begin
            state_q <= StIdle;
          end else begin
            wbuf_q[wlen_q[uwfc_pkg::PosW-1:0]] <=
              (need == 3'd1 && seq_q[0] >= 8'h41 && seq_q[0] <= 8'h5A) ?
              seq_q[0] + 8'h20 : seq_q[apos_q[1:0]];
            wlen_q <= wlen_q + 1'b1;
            apos_q <= apos_q + 3'd1;
          end
        end
        StFinish: begin
          if (wlen_q == '0) begin
            if (after_q) begin
              apos_q <= '0;
              state_q <= StAppend;
            end else if (redo_q) begin
              state_q <= StDecode;
            end else begin
              state_q <= StIdle;
            end
          end else begin
            slot_q <= '0;
            state_q <= StLenRd;
          end
        end
        StLenRd: begin
          pos_q <= '0;
          if (slot_q == used_q) begin
            if (bslot_full) begin
              slot_q <= '0;
              state_q <= StMinRd;
            end else begin
              tgt_q <= used_q[uwfc_pkg::SlotW-1:0];
              act_q <= uwfc_pkg::ActAppended;
              used_q <= used_q + 1'b1;
              state_q <= StWrite;
            end
          end else begin
            state_q <= StLenChk;
          end
        end
        StLenChk: begin
          // lrd_q and brd_q for pos 0 are valid here
          if (lrd_q != wlen_q || brd_q != wbuf_q[0]) begin
            slot_q <= slot_q + 1'b1;
            state_q <= StLenRd;
          end else if (wlen_q == uwfc_pkg::LenW'(1)) begin
            tgt_q <= slot_q[uwfc_pkg::SlotW-1:0];
            state_q <= StCntRd;
          end else begin
            pos_q <= uwfc_pkg::PosW'(1);
            state_q <= StByteChk;
          end
        end
        StByteChk: begin
          // brd_q holds the stored byte at pos_q; the next one is being read
          if (brd_q != wbuf_q[pos_q]) begin
            slot_q <= slot_q + 1'b1;
            state_q <= StLenRd;
          end else if (uwfc_pkg::LenW'(pos_q) + 1'b1 == wlen_q) begin
            tgt_q <= slot_q[uwfc_pkg::SlotW-1:0];
            state_q <= StCntRd;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
        StCntRd: state_q <= StCntUpd;
        StCntUpd: begin
          res_word_o <= {uwfc_pkg::ActRaised, 6'(tgt_q), cwdata, 5'(wlen_q)};
          wlen_q <= '0;
          if (after_q) begin
            apos_q <= '0;
            state_q <= StAppend;
          end else if (redo_q) begin
            state_q <= StDecode;
          end else begin
            state_q <= StIdle;
          end
        end
        StMinRd: begin
          // crd_q of slot_q-1 valid once slot_q > 0
          if (slot_q != '0) begin
            if (slot_q == uwfc_pkg::UsedW'(1) || crd_q < wcnt_q) begin
              wcnt_q <= crd_q;
              weak_q <= uwfc_pkg::SlotW'(slot_q - 1'b1);
            end
          end
          if (slot_q == uwfc_pkg::UsedW'(uwfc_pkg::TableEntries)) state_q <= StMinChk;
          else slot_q <= slot_q + 1'b1;
        end
        StMinChk: begin
          if (wcnt_q > 32'd1) begin
            res_word_o <= {uwfc_pkg::ActDropped, 6'd0, 32'd0, 5'(wlen_q)};
            wlen_q <= '0;
            if (after_q) begin
              apos_q <= '0;
              state_q <= StAppend;
            end else if (redo_q) begin
              state_q <= StDecode;
            end else begin
              state_q <= StIdle;
            end
          end else begin
            tgt_q <= weak_q;
            act_q <= uwfc_pkg::ActReplaced;
            pos_q <= '0;
            state_q <= StWrite;
          end
        end
        StWrite: begin
          if (uwfc_pkg::LenW'(pos_q) + 1'b1 == wlen_q) begin
            res_word_o <= {act_q, 6'(tgt_q), 32'd1, 5'(wlen_q)};
            wlen_q <= '0;
            if (after_q) begin
              apos_q <= '0;
              state_q <= StAppend;
            end else if (redo_q) begin
              state_q <= StDecode;
            end else begin
              state_q <= StIdle;
            end
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

[tb/sv/testbench.sv]
// Testbench for the UTF-8 word frequency counter: a scoreboard class that
// predicts table updates, plain tasks that drive text. Uses uwfc_pkg.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 10000000;
  localparam int RandomItems = 900;
  localparam int VocabSize = 70;

  // Predict table updates and compare them with the block's results.
  class word_tally_sb;
    logic [7:0]  tbl_bytes [uwfc_pkg::TableEntries][uwfc_pkg::WordBufferBytes];
    logic [4:0]  tbl_len [uwfc_pkg::TableEntries];
    logic [31:0] tbl_cnt [uwfc_pkg::TableEntries];
    int          used;
    logic [7:0]  gather [uwfc_pkg::WordBufferBytes];
    int          glen;
    logic [7:0]  pend [3];
    int          pcnt;
    uwfc_pkg::out_word_t expected_updates[$];
    int          errors;

    function new();
      used = 0;
      glen = 0;
      pcnt = 0;
      errors = 0;
    endfunction

    function bit is_word_point(int unsigned cp);
      if (cp < 'h80)
        return (cp >= "a" && cp <= "z") || (cp >= "A" && cp <= "Z") ||
               (cp >= "0" && cp <= "9") || cp == "_" || cp == "-";
      if (cp == 'hA0 || cp == 'h1680 || cp == 'h180E) return 0;
      if ((cp >= 'h2000 && cp <= 'h206F) || (cp >= 'h2E00 && cp <= 'h2E7F) ||
          (cp >= 'h3000 && cp <= 'h303F) || (cp >= 'hFE30 && cp <= 'hFE4F))
        return 0;
      return 1;
    endfunction

    function void put_gathered(int slot);
      for (int j = 0; j < glen; j++) tbl_bytes[slot][j] = gather[j];
      tbl_len[slot] = glen[4:0];
      tbl_cnt[slot] = 32'd1;
    endfunction

    // Look the gathered word up, then raise, append, replace or drop.
    function void tally_word();
      uwfc_pkg::out_word_t o;
      int hit;
      int low_slot;
      bit same;
      hit = -1;
      o = '0;
      o.word_length = glen[4:0];
      for (int i = 0; i < used && hit < 0; i++) begin
        if (tbl_len[i] == glen[4:0]) begin
          same = 1;
          for (int j = 0; j < glen; j++) if (tbl_bytes[i][j] != gather[j]) same = 0;
          if (same) hit = i;
        end
      end
      if (hit >= 0) begin
        if (tbl_cnt[hit] != 32'hFFFF_FFFF) tbl_cnt[hit] += 1;
        o.action = uwfc_pkg::ActRaised;
        o.slot_index = hit[5:0];
        o.slot_count = tbl_cnt[hit];
      end else if (used >= uwfc_pkg::TableEntries) begin
        low_slot = 0;
        for (int i = 1; i < uwfc_pkg::TableEntries; i++)
          if (tbl_cnt[i] < tbl_cnt[low_slot]) low_slot = i;
        if (tbl_cnt[low_slot] > 1) begin
          o.action = uwfc_pkg::ActDropped;
        end else begin
          put_gathered(low_slot);
          o.action = uwfc_pkg::ActReplaced;
          o.slot_index = low_slot[5:0];
          o.slot_count = 32'd1;
        end
      end else begin
        put_gathered(used);
        o.action = uwfc_pkg::ActAppended;
        o.slot_index = used[5:0];
        o.slot_count = 32'd1;
        used++;
      end
      expected_updates.push_back(o);
    endfunction

    function void finish_word();
      if (glen == 0) return;
      tally_word();
      glen = 0;
    endfunction

    // Add one decoded code point, cutting the word when it would overflow.
    function void take_point(int unsigned cp, logic [7:0] seq [4], int n);
      logic [7:0] ch;
      if (!is_word_point(cp)) begin
        finish_word();
        return;
      end
      if (glen + n >= uwfc_pkg::WordBufferBytes) finish_word();
      for (int i = 0; i < n; i++) begin
        ch = seq[i];
        if (cp < 'h80 && ch >= "A" && ch <= "Z") ch = ch + 8'h20;
        gather[glen] = ch;
        glen++;
      end
    endfunction

    function void fresh_byte(logic [7:0] b);
      logic [7:0] seq [4];
      seq = '{b, 8'h00, 8'h00, 8'h00};
      if (b < 8'h80) begin
        take_point(b, seq, 1);
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
        pend[0] = b;
        pcnt = 1;
      end else begin
        finish_word();
      end
    endfunction

    function void text_in(logic [7:0] b);
      logic [7:0] seq [4];
      int need;
      int unsigned cp;
      if (pcnt == 0) begin
        fresh_byte(b);
        return;
      end
      // Drop a broken sequence: its bytes act as separators.
      if (b[7:6] != 2'b10) begin
        pcnt = 0;
        finish_word();
        fresh_byte(b);
        return;
      end
      need = (pend[0][7:5] == 3'b110) ? 2 : (pend[0][7:4] == 4'b1110) ? 3 : 4;
      if (pcnt + 1 < need) begin
        pend[pcnt] = b;
        pcnt++;
        return;
      end
      seq = '{8'h00, 8'h00, 8'h00, 8'h00};
      for (int i = 0; i < pcnt; i++) seq[i] = pend[i];
      seq[pcnt] = b;
      pcnt = 0;
      if (need == 2)
        cp = {seq[0][4:0], seq[1][5:0]};
      else if (need == 3)
        cp = {seq[0][3:0], seq[1][5:0], seq[2][5:0]};
      else
        cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
      take_point(cp, seq, need);
    endfunction

    function void note_input(uwfc_pkg::in_word_t w);
      case (uwfc_pkg::kind_e'(w.kind))
        uwfc_pkg::KindByte: text_in(w.text_byte);
        uwfc_pkg::KindFlush: begin
          pcnt = 0;
          finish_word();
        end
        uwfc_pkg::KindClear: used = 0;
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(uwfc_pkg::out_word_t r);
      uwfc_pkg::out_word_t e;
      if (expected_updates.size() == 0) begin
        report($sformatf("unexpected result %p", r));
        return;
      end
      e = expected_updates.pop_front();
      if (r.action != e.action) report($sformatf("action %0d want %0d", r.action, e.action));
      if (r.slot_index != e.slot_index)
        report($sformatf("slot %0d want %0d", r.slot_index, e.slot_index));
      if (r.slot_count != e.slot_count)
        report($sformatf("count %0d want %0d", r.slot_count, e.slot_count));
      if (r.word_length != e.word_length)
        report($sformatf("length %0d want %0d", r.word_length, e.word_length));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  uwfc_pkg::in_word_t  in_word_i;
  logic        busy_o;
  logic        res_valid_o;
  uwfc_pkg::out_word_t res_word_o;

  word_tally_sb sb;
  int unsigned  cycles = 0;
  int           sent;
  int           idle_pct;
  logic [7:0]   vocab [VocabSize][$];

  utf8_word_frequency_counter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .in_word_i  (in_word_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_word_o (res_word_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Bound the run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Check every result strobe.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_result(res_word_o);
  end

  // Hand one word to the block, with a random gap first.
  task automatic send_item(uwfc_pkg::kind_e k, logic [7:0] b);
    int gap;
    gap = 0;
    while (idle_pct > 0 && gap < 8 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_word_i <= '{kind: k, text_byte: b};
    do @(posedge clk_i); while (busy_o);
    sb.note_input(in_word_i);
    sent++;
  endtask

  task automatic send_text(logic [7:0] q [$]);
    foreach (q[i]) send_item(uwfc_pkg::KindByte, q[i]);
  endtask

  function automatic void add_point(ref logic [7:0] q [$]);
    int c;
    c = $urandom_range(0, 10);
    if (c <= 5) begin
      q.push_back($urandom_range(0, 1) ? 8'(65 + $urandom_range(0, 25))
                                       : 8'(97 + $urandom_range(0, 25)));
    end else if (c == 6) begin
      q.push_back(8'(48 + $urandom_range(0, 9)));
    end else if (c == 7) begin
      q.push_back($urandom_range(0, 1) ? 8'h5F : 8'h2D);
    end else if (c == 8) begin
      q.push_back(8'($urandom_range('hC0, 'hDF)));
      q.push_back(8'($urandom_range('h80, 'hBF)));
    end else if (c == 9) begin
      q.push_back(8'($urandom_range('hE0, 'hEF)));
      q.push_back(8'($urandom_range('h80, 'hBF)));
      q.push_back(8'($urandom_range('h80, 'hBF)));
    end else begin
      q.push_back(8'($urandom_range('hF0, 'hF7)));
      repeat (3) q.push_back(8'($urandom_range('h80, 'hBF)));
    end
  endfunction

  function automatic void add_separator(ref logic [7:0] q [$]);
    case ($urandom_range(0, 8))
      0, 1: q.push_back(8'h20);
      2: q.push_back(8'h2E);
      3: q.push_back(8'h00);
      4: begin
        q.push_back(8'hE2);
        q.push_back(8'h80);
        q.push_back(8'($urandom_range('h80, 'hAF)));
      end
      5: begin
        q.push_back(8'hE3);
        q.push_back(8'h80);
        q.push_back(8'h80);
      end
      6: begin
        q.push_back(8'hEF);
        q.push_back(8'hB8);
        q.push_back(8'hB0);
      end
      7: q.push_back(8'($urandom_range('h80, 'hBF)));
      default: q.push_back(8'($urandom_range('hF8, 'hFF)));
    endcase
  endfunction

  initial begin
    logic [7:0] q [$];
    logic [7:0] tmp [$];
    int r;
    sb = new();
    sent = 0;
    idle_pct = 0;
    start_i = 1'b0;
    in_word_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: case folding, multibyte forms, broken and lone bytes, flush.
    send_text({8'h41, 8'h62, 8'h5A, 8'h39, 8'h5F, 8'h2D, 8'h20, 8'h61, 8'h62, 8'h7A});
    send_text({8'h00, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80});
    send_text({8'hC3, 8'h41, 8'h80, 8'h62, 8'hFF, 8'hE2, 8'h80, 8'hA8, 8'h63});
    send_item(uwfc_pkg::KindNone, 8'hFF);
    send_text({8'hE2, 8'h80});
    send_item(uwfc_pkg::KindFlush, 8'h00);
    send_item(uwfc_pkg::KindClear, 8'hAA);
    send_item(uwfc_pkg::KindFlush, 8'h55);

    for (int i = 0; i < VocabSize; i++) begin
      tmp = {};
      repeat ($urandom_range(1, 3)) add_point(tmp);
      vocab[i] = tmp;
    end

    // Random: mostly a recurring vocabulary, some noise and long words.
    while (sent < RandomItems + 30) begin
      case ((sent * 4) / (RandomItems + 30))
        0: idle_pct = 0;
        1: idle_pct = 50;
        2: idle_pct = 0;
        default: idle_pct = 15;
      endcase
      q = {};
      r = $urandom_range(0, 99);
      if (r < 70) begin
        q = vocab[$urandom_range(0, VocabSize - 1)];
      end else if (r < 80) begin
        repeat ($urandom_range(1, 5)) add_point(q);
      end else if (r < 85) begin
        repeat ($urandom_range(33, 45)) q.push_back(8'(97 + $urandom_range(0, 2)));
      end else if (r < 92) begin
        repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 95) begin
        send_item(uwfc_pkg::KindFlush, 8'($urandom_range(0, 255)));
      end else if (r < 98) begin
        send_item(uwfc_pkg::KindNone, 8'($urandom_range(0, 255)));
      end else if (r < 99) begin
        send_item(uwfc_pkg::KindClear, 8'($urandom_range(0, 255)));
      end
      add_separator(q);
      send_text(q);
    end
    send_item(uwfc_pkg::KindFlush, 8'h00);
    start_i <= 1'b0;

    // Drain, then allow for a last table walk.
    while (sb.expected_updates.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/uwfc_pkg.sv
hw/rtl/utf8_word_frequency_counter.sv
tb/sv/testbench.sv
